// File: rtl/pkhm_pkg.sv
`default_nettype none
package pkhm_pkg;
    localparam int NUM_BUCKETS_DEF = 256;
    localparam int CAPACITY_DEF    = 256;

    typedef enum logic [1:0] {
        CMD_SET = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_HEADW,
        S_SLOT,
        S_SLOTW,
        S_FREE,
        S_FREEW,
        S_UPD,
        S_UPD2,
        S_OUT,
        S_INIT
    } t_state;
endpackage
`default_nettype wire

// File: rtl/pkhm_ram.sv
`default_nettype none
module pkhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/page_keyed_hash_map_unit.sv
// Each item reads its bucket head, then walks the chain one slot at a time until the key
//   matches or the chain ends; command three (no-op) goes to the result after the head read.
// A set on a miss then pops a free slot, or reports full when the pool is full; a delete
//   hit unlinks its slot and pushes it back on the free stack.
// Only one item is in flight: a new input is taken only in the idle state, after the result.
// Reset: synchronous, active low. After reset a clearing pass writes every bucket head and
//   every free-list entry in parallel, with input stalled.
`default_nettype none
module page_keyed_hash_map_unit
    import pkhm_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int CAPACITY    = CAPACITY_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: page[63:0], new_header[127:64], new_value[191:128]
    input  wire logic [191:0] s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: result_header[63:0], result_value[127:64]
    output logic [127:0]      m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]        m_axis_tuser
);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int SW = $clog2(CAPACITY);
    localparam int LW = SW + 1;            // link width; CAPACITY is the end mark
    localparam int IW = (BW > SW ? BW : SW) + 1;
    localparam logic [LW-1:0] NO_SLOT = LW'(CAPACITY);
    localparam int SLOTW = 64 + 64 + 64 + LW;   // key, header, value, link

    t_state r_state, n_state;

    logic [1:0]  r_cmd;
    logic [63:0] r_page, r_nh, r_nv;
    logic [LW-1:0] r_cur, r_prev, r_cnt, r_fs, r_nxt;
    logic [LW-1:0] r_steps;
    logic [63:0] r_rh, r_rv;
    logic [1:0]  r_st;
    logic [IW-1:0] r_init;
    // full word of the predecessor slot, kept so its link can be rewritten without a read
    logic [SLOTW-1:0] r_pv;

    // bucket head memory
    logic          h_we;
    logic [BW-1:0] h_wa, h_ra;
    logic [LW-1:0] h_wd, h_rd;
    // slot memory: {link, value, header, key}
    logic             s_we;
    logic [SW-1:0]    s_wa, s_ra;
    logic [SLOTW-1:0] s_wd, s_rd;
    // free stack memory
    logic          f_we;
    logic [SW-1:0] f_wa, f_ra;
    logic [SW-1:0] f_wd, f_rd;

    pkhm_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd));
    pkhm_ram #(.WIDTH(SLOTW), .DEPTH(CAPACITY)) u_slots (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    pkhm_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(f_wd),
        .i_raddr(f_ra), .o_rdata(f_rd));

    wire [63:0]    rd_key  = s_rd[63:0];
    wire [63:0]    rd_hdr  = s_rd[127:64];
    wire [63:0]    rd_val  = s_rd[191:128];
    wire [LW-1:0]  rd_link = s_rd[SLOTW-1:192];
    wire [BW-1:0]  bkt     = r_page[BW-1:0];
    wire           s_acc   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_rv, r_rh};
    assign m_axis_tuser  = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) r_init <= r_init + 1'b1;
            if (r_state == S_UPD2 && r_cmd == CMD_SET) r_cnt <= r_cnt + 1'b1;
            if (r_state == S_UPD2 && r_cmd == CMD_DEL) r_cnt <= r_cnt - 1'b1;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_cmd  <= s_axis_tuser;
                    r_page <= s_axis_tdata[63:0];
                    r_nh   <= s_axis_tdata[127:64];
                    r_nv   <= s_axis_tdata[191:128];
                    r_prev <= NO_SLOT;
                    r_steps <= '0;
                    r_rh <= '0;
                    r_rv <= '0;
                    r_st <= ST_NOTFOUND;
                end
            end
            S_HEADW: r_cur <= h_rd;
            S_SLOTW: begin
                if (rd_key == r_page) begin
                    r_rh  <= rd_hdr;
                    r_rv  <= rd_val;
                    r_nxt <= rd_link;
                    r_st  <= ST_OK;
                end else begin
                    r_prev  <= r_cur;
                    r_pv    <= s_rd;
                    r_cur   <= rd_link;
                    r_steps <= r_steps + 1'b1;
                end
            end
            S_FREEW: begin
                if (r_cnt >= NO_SLOT) r_st <= ST_FULL;
                else begin
                    r_fs <= {1'b0, f_rd};
                    r_st <= ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        h_we = 1'b0; h_wa = bkt; h_wd = NO_SLOT; h_ra = s_axis_tdata[BW-1:0];
        s_we = 1'b0; s_wa = r_cur[SW-1:0]; s_wd = '0; s_ra = r_cur[SW-1:0];
        f_we = 1'b0; f_wa = r_init[SW-1:0]; f_wd = r_init[SW-1:0];
        f_ra = r_cnt[SW-1:0];
        case (r_state)
            S_INIT: begin
                h_we = (r_init < IW'(NUM_BUCKETS));
                h_wa = r_init[BW-1:0];
                f_we = (r_init < IW'(CAPACITY));
                if (r_init >= IW'(NUM_BUCKETS - 1) && r_init >= IW'(CAPACITY - 1))
                    n_state = S_IDLE;
            end
            S_IDLE: if (s_acc) n_state = S_HEADW;
            S_HEADW: n_state = S_SLOT;
            S_SLOT: begin
                if (r_cmd == CMD_NOP) n_state = S_OUT;
                else if (r_cur >= NO_SLOT || r_steps >= NO_SLOT) begin
                    // key absent
                    n_state = (r_cmd == CMD_SET) ? S_FREE : S_OUT;
                end else n_state = S_SLOTW;
            end
            S_SLOTW: begin
                if (rd_key == r_page)
                    n_state = (r_cmd == CMD_GET) ? S_OUT : S_UPD;
                else n_state = S_SLOT;
            end
            S_FREE: n_state = S_FREEW;
            S_FREEW: n_state = (r_cnt >= NO_SLOT) ? S_OUT : S_UPD;
            S_UPD: begin
                if (r_cmd == CMD_SET && r_cur < NO_SLOT) begin
                    // replace in place
                    s_we = 1'b1;
                    s_wd = {r_nxt, r_nv, r_nh, r_page};
                    n_state = S_OUT;
                end else if (r_cmd == CMD_SET) begin
                    // new slot at chain end
                    s_we = 1'b1;
                    s_wa = r_fs[SW-1:0];
                    s_wd = {NO_SLOT, r_nv, r_nh, r_page};
                    n_state = S_UPD2;
                end else begin
                    // delete: link predecessor or head past the slot
                    if (r_prev < NO_SLOT) begin
                        s_we = 1'b1;
                        s_wa = r_prev[SW-1:0];
                        s_wd = {r_nxt, r_pv[SLOTW-LW-1:0]};
                    end else begin
                        h_we = 1'b1;
                        h_wd = r_nxt;
                    end
                    n_state = S_UPD2;
                end
            end
            S_UPD2: begin
                if (r_cmd == CMD_SET) begin
                    // hook the new slot onto the old tail or the bucket head
                    if (r_prev < NO_SLOT) begin
                        s_we = 1'b1;
                        s_wa = r_prev[SW-1:0];
                        s_wd = {r_fs, r_pv[SLOTW-LW-1:0]};
                    end else begin
                        h_we = 1'b1;
                        h_wd = r_fs;
                    end
                end else begin
                    // push the freed slot back on the free stack
                    f_we = 1'b1;
                    f_wa = SW'(r_cnt - 1'b1);
                    f_wd = r_cur[SW-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser));
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid));
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NO_SLOT);
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_FULL);
endmodule
`default_nettype wire
